FILE: design/sjq_pkg.sv
// Shared types and codes for the sorted job queue.
package sjq_pkg;

  localparam int TIME_W   = 32;
  localparam int STATUS_W = 2;

  // Item opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Command broadcast to every cell in the chain
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [TIME_W-1:0] job_time;
  } cmd_t;

  // What a cell shows its neighbors
  typedef struct packed {
    logic              valid;
    logic              le;        // valid and time <= new job time
    logic [TIME_W-1:0] job_time;
  } link_t;

endpackage

FILE: design/sjq_cell.sv
// One slot of the sorted chain: holds a job and shifts with its neighbors.
module sjq_cell #(
  parameter int TAG_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sjq_pkg::cmd_t       cmd,
  input  logic [TAG_BITS-1:0] new_tag,
  input  sjq_pkg::link_t      left,
  input  logic [TAG_BITS-1:0] left_tag,
  input  sjq_pkg::link_t      right,
  input  logic [TAG_BITS-1:0] right_tag,
  output sjq_pkg::link_t      self_link,
  output logic [TAG_BITS-1:0] self_tag
);
  import sjq_pkg::*;

  logic                valid_r, valid_nxt;
  logic [TIME_W-1:0]   time_r, time_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  logic                le;

  // Compare own job against the broadcast time
  assign le = valid_r && (time_r <= cmd.job_time);

  assign self_link.valid    = valid_r;
  assign self_link.le       = le;
  assign self_link.job_time = time_r;
  assign self_tag           = tag_r;

  // Keep, take the new job, or shift from a neighbor
  always_comb begin
    valid_nxt = valid_r;
    time_nxt  = time_r;
    tag_nxt   = tag_r;
    priority if (cmd.ins) begin
      if (le) begin
        valid_nxt = valid_r;
      end else if (left.le) begin
        valid_nxt = 1'b1;
        time_nxt  = cmd.job_time;
        tag_nxt   = new_tag;
      end else begin
        valid_nxt = left.valid;
        time_nxt  = left.job_time;
        tag_nxt   = left_tag;
      end
    end else if (cmd.rem) begin
      valid_nxt = right.valid;
      time_nxt  = right.job_time;
      tag_nxt   = right_tag;
    end else begin
      valid_nxt = valid_r;
    end
  end

  // Valid bit cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold job payload
  always_ff @(posedge clk) begin
    time_r <= time_nxt;
    tag_r  <= tag_nxt;
  end

endmodule

FILE: design/sorted_job_queue_unit.sv
// Top level of the sorted job queue: a chain of cells kept in time order.
//
//   channel | direction | handshake            | payload
//   in_     | input     | start / busy         | opcode, job_time, job_tag
//   out_    | output    | out_valid (strobe)   | status, head_valid, head_time,
//           |           |                      | head_tag, job_count
//
// One item per clock: every cell compares its job with the new time and
// decides locally to keep, take the new job or shift from a neighbor, so
// an item finishes in the cycle it is accepted and busy stays low.
// The result strobes in the cycle after acceptance.
// Reset (synchronous, rst_n low) empties the queue at once.
// The receiver cannot stall; each result is shown for exactly one cycle.
module sorted_job_queue_unit #(
  parameter int  QUEUE_DEPTH = 16,
  parameter int  TAG_BITS    = 16,
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_opcode,
  input  logic [sjq_pkg::TIME_W-1:0]   in_job_time,
  input  logic [TAG_BITS-1:0]          in_job_tag,
  output logic                         out_valid,
  output logic [sjq_pkg::STATUS_W-1:0] out_status,
  output logic                         out_head_valid,
  output logic [sjq_pkg::TIME_W-1:0]   out_head_time,
  output logic [TAG_BITS-1:0]          out_head_tag,
  output logic [CNT_W-1:0]             out_job_count
);
  import sjq_pkg::*;

  logic                accept;
  logic                full;
  logic                empty;
  cmd_t                cmd;
  link_t               links [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] tags  [QUEUE_DEPTH];
  link_t               head_left;
  link_t               tail_right;
  logic [QUEUE_DEPTH-1:0] valid_vec;

  logic [CNT_W-1:0] count_r, count_nxt;
  status_t          status_r, status_nxt;
  logic             strobe_r, strobe_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty  = (count_r == '0);

  // Broadcast command; drop inserts into a full queue, removes from empty
  assign cmd.ins      = accept && (in_opcode == OP_INSERT) && !full;
  assign cmd.rem      = accept && (in_opcode == OP_REMOVE) && !empty;
  assign cmd.job_time = in_job_time;

  // Chain ends: the head sees an always-earlier neighbor, the tail an empty one
  assign head_left.valid     = 1'b1;
  assign head_left.le        = 1'b1;
  assign head_left.job_time  = '0;
  assign tail_right.valid    = 1'b0;
  assign tail_right.le       = 1'b0;
  assign tail_right.job_time = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    link_t               l_link, r_link;
    logic [TAG_BITS-1:0] l_tag, r_tag;

    if (i == 0) begin : g_head
      assign l_link = head_left;
      assign l_tag  = '0;
    end else begin : g_mid_l
      assign l_link = links[i-1];
      assign l_tag  = tags[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_link = tail_right;
      assign r_tag  = '0;
    end else begin : g_mid_r
      assign r_link = links[i+1];
      assign r_tag  = tags[i+1];
    end

    sjq_cell #(
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .new_tag   (in_job_tag),
      .left      (l_link),
      .left_tag  (l_tag),
      .right     (r_link),
      .right_tag (r_tag),
      .self_link (links[i]),
      .self_tag  (tags[i])
    );

    assign valid_vec[i] = links[i].valid;
  end

  // Count, status and result strobe
  always_comb begin
    count_nxt  = count_r;
    status_nxt = status_r;
    strobe_nxt = accept;
    if (accept) begin
      priority if (cmd.ins) begin
        count_nxt  = count_r + 1'b1;
        status_nxt = ST_OK;
      end else if (cmd.rem) begin
        count_nxt  = count_r - 1'b1;
        status_nxt = ST_OK;
      end else if (in_opcode == OP_INSERT) begin
        status_nxt = ST_FULL;
      end else begin
        status_nxt = ST_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      status_r <= ST_OK;
      strobe_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      status_r <= status_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Present the head cell; zero its payload when the queue is empty
  assign out_valid      = strobe_r;
  assign out_status     = status_r;
  assign out_head_valid = links[0].valid;
  assign out_head_time  = links[0].valid ? links[0].job_time : '0;
  assign out_head_tag   = links[0].valid ? tags[0] : '0;
  assign out_job_count  = count_r;

  // Every accepted item gives exactly one strobe in the next cycle
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("missing result strobe");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid)
    else $error("result strobe without item");

  // Occupied cells match the count
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(count_r))
    else $error("cell valid bits disagree with job count");

  // A dropped insert leaves the queue unchanged
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_opcode == OP_INSERT) && full) |=>
      ($stable(count_r) && (out_status == ST_FULL)))
    else $error("insert into full queue changed state");

  // Head order: the head never holds a later time than its successor
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    links[1].valid |-> (links[0].job_time <= links[1].job_time))
    else $error("head out of order");

endmodule
